>>> rtl/smbht_pkg.sv
// ----------------------------------------------------------------------------
// SMBus host sequencer package
// Shared types, codes and tables for the transaction sequencer.
// ----------------------------------------------------------------------------
package smbht_pkg;

  localparam logic [1:0] FN_REQ    = 2'd0;
  localparam logic [1:0] FN_CPL    = 2'd1;
  localparam logic [1:0] FN_PAY    = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [1:0] OK_OP   = 2'd0;
  localparam logic [1:0] OK_PREQ = 2'd1;
  localparam logic [1:0] OK_RX   = 2'd2;
  localparam logic [1:0] OK_DONE = 2'd3;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_RSTART = 3'd1;
  localparam logic [2:0] OP_SEND   = 3'd2;
  localparam logic [2:0] OP_RACK   = 3'd3;
  localparam logic [2:0] OP_RNACK  = 3'd4;
  localparam logic [2:0] OP_STOP   = 3'd5;

  localparam logic [4:0] ST_START   = 5'd1;
  localparam logic [4:0] ST_RSTART  = 5'd2;
  localparam logic [4:0] ST_ADDRW   = 5'd3;
  localparam logic [4:0] ST_DATA_TX = 5'd5;
  localparam logic [4:0] ST_ADDRR   = 5'd8;
  localparam logic [4:0] ST_RX_ACK  = 5'd10;
  localparam logic [4:0] ST_RX_NACK = 5'd11;

  localparam logic [3:0] K_QUICK  = 4'd0;
  localparam logic [3:0] K_SEND   = 4'd1;
  localparam logic [3:0] K_RECV   = 4'd2;
  localparam logic [3:0] KW_BYTE  = 4'd3;
  localparam logic [3:0] KW_WORD  = 4'd4;
  localparam logic [3:0] KR_BYTE  = 4'd5;
  localparam logic [3:0] KR_WORD  = 4'd6;
  localparam logic [3:0] K_PCALL  = 4'd7;
  localparam logic [3:0] K_BLKW   = 4'd8;
  localparam logic [3:0] K_BLKR   = 4'd9;
  localparam logic [3:0] K_BLKPC  = 4'd10;
  localparam logic [3:0] K_WR32   = 4'd11;
  localparam logic [3:0] K_RD32   = 4'd12;
  localparam logic [3:0] K_WR64   = 4'd13;
  localparam logic [3:0] K_RD64   = 4'd14;
  localparam logic [3:0] K_UNUSED = 4'd15;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b000000000001,
    PH_START   = 12'b000000000010,
    PH_ADDRW   = 12'b000000000100,
    PH_CMD     = 12'b000000001000,
    PH_WDATA   = 12'b000000010000,
    PH_WCOUNT  = 12'b000000100000,
    PH_PAYREQ  = 12'b000001000000,
    PH_PAYLOAD = 12'b000010000000,
    PH_RSTART  = 12'b000100000000,
    PH_ADDRR   = 12'b001000000000,
    PH_RLEN    = 12'b010000000000,
    PH_RDATA   = 12'b100000000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  kind;
    logic [6:0]  dev_addr;
    logic [7:0]  command;
    logic [63:0] write_value;
    logic [7:0]  write_count;
    logic [4:0]  phy_status;
    logic [7:0]  phy_rx_byte;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [2:0]  phy_op;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_index;
    logic [7:0]  rx_data;
    logic        done_error;
    logic [4:0]  error_status;
    logic [63:0] read_value;
    logic [7:0]  rx_count;
    logic        last_result;
  } out_item_t;

  // Up to three results per input item
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } res_set_t;

  function automatic logic [3:0] wr_bytes(input logic [3:0] k);
    unique case (k) inside
      K_SEND, KW_BYTE:  wr_bytes = 4'd1;
      KW_WORD, K_PCALL: wr_bytes = 4'd2;
      K_WR32:           wr_bytes = 4'd4;
      K_WR64:           wr_bytes = 4'd8;
      default:          wr_bytes = 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] rd_bytes(input logic [3:0] k);
    unique case (k) inside
      K_RECV, KR_BYTE:  rd_bytes = 4'd1;
      KR_WORD, K_PCALL: rd_bytes = 4'd2;
      K_RD32:           rd_bytes = 4'd4;
      K_RD64:           rd_bytes = 4'd8;
      default:          rd_bytes = 4'd0;
    endcase
  endfunction

endpackage

>>> rtl/smbht_core.sv
// ----------------------------------------------------------------------------
// SMBus host sequencer core
// Transaction state and per-item next-state / result logic.
// ----------------------------------------------------------------------------
module smbht_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  smbht_pkg::in_item_t item,
  output smbht_pkg::res_set_t res
);

  smbht_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [63:0] val_r, val_nxt;
  logic [7:0]  scnt_r, scnt_nxt;
  logic [7:0]  bcnt_r, bcnt_nxt;
  logic [7:0]  rlen_r, rlen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  exp_r, exp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= smbht_pkg::PH_IDLE;
      kind_r  <= '0;
      addr_r  <= '0;
      cmd_r   <= '0;
      val_r   <= '0;
      scnt_r  <= '0;
      bcnt_r  <= '0;
      rlen_r  <= '0;
      acc_r   <= '0;
      exp_r   <= '0;
    end else if (item_vld) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      val_r   <= val_nxt;
      scnt_r  <= scnt_nxt;
      bcnt_r  <= bcnt_nxt;
      rlen_r  <= rlen_nxt;
      acc_r   <= acc_nxt;
      exp_r   <= exp_nxt;
    end
  end

  logic blk_w, blk_r;
  assign blk_w = (kind_r == smbht_pkg::K_BLKW) || (kind_r == smbht_pkg::K_BLKPC);
  assign blk_r = (kind_r == smbht_pkg::K_BLKR) || (kind_r == smbht_pkg::K_BLKPC);

  logic [7:0] bcnt_inc;
  assign bcnt_inc = bcnt_r + 8'd1;

  always_comb begin
    smbht_pkg::out_item_t r [3];
    logic [1:0] n;
    logic       do_fin, do_aw, do_wd, do_pl, do_rx;
    logic [7:0] bc;
    logic [63:0] acc;
    logic [7:0]  rl;
    for (int i = 0; i < 3; i++) r[i] = '0;
    n = 2'd0;
    do_fin = 1'b0; do_aw = 1'b0; do_wd = 1'b0; do_pl = 1'b0; do_rx = 1'b0;
    bc  = bcnt_r;
    acc = acc_r;
    rl  = rlen_r;
    phase_nxt = phase_r;
    kind_nxt = kind_r; addr_nxt = addr_r; cmd_nxt = cmd_r; val_nxt = val_r;
    scnt_nxt = scnt_r; exp_nxt = exp_r;

    unique case (item.func)
      smbht_pkg::FN_REQ: begin
        if (phase_r == smbht_pkg::PH_IDLE && item.kind != smbht_pkg::K_UNUSED) begin
          kind_nxt = item.kind;
          addr_nxt = item.dev_addr;
          cmd_nxt  = item.command;
          val_nxt  = item.write_value;
          scnt_nxt = ((item.kind == smbht_pkg::K_BLKW) || (item.kind == smbht_pkg::K_BLKPC))
                     ? item.write_count : {4'd0, smbht_pkg::wr_bytes(item.kind)};
          bc  = '0;
          rl  = {4'd0, smbht_pkg::rd_bytes(item.kind)};
          acc = '0;
          r[0].phy_op = smbht_pkg::OP_START;
          n = 2'd1;
          phase_nxt = smbht_pkg::PH_START;
          exp_nxt = smbht_pkg::ST_START;
        end
      end
      smbht_pkg::FN_CPL: begin
        if (phase_r != smbht_pkg::PH_IDLE && phase_r != smbht_pkg::PH_PAYREQ) begin
          if (item.phy_status != exp_r) begin
            r[0].out_kind     = smbht_pkg::OK_DONE;
            r[0].done_error   = 1'b1;
            r[0].error_status = item.phy_status;
            n = 2'd1;
            phase_nxt = smbht_pkg::PH_IDLE;
            exp_nxt = '0;
          end else begin
            unique case (phase_r) inside
              smbht_pkg::PH_START: begin
                r[0].phy_op = smbht_pkg::OP_SEND;
                n = 2'd1;
                if (kind_r == smbht_pkg::K_RECV) begin
                  r[0].tx_byte = {addr_r, 1'b1};
                  phase_nxt = smbht_pkg::PH_ADDRR;
                  exp_nxt = smbht_pkg::ST_ADDRR;
                end else begin
                  r[0].tx_byte = {addr_r, 1'b0};
                  phase_nxt = smbht_pkg::PH_ADDRW;
                  exp_nxt = smbht_pkg::ST_ADDRW;
                end
              end
              smbht_pkg::PH_ADDRW: begin
                if (kind_r == smbht_pkg::K_QUICK) do_fin = 1'b1;
                else if (kind_r == smbht_pkg::K_SEND) do_wd = 1'b1;
                else begin
                  r[0].phy_op = smbht_pkg::OP_SEND;
                  r[0].tx_byte = cmd_r;
                  n = 2'd1;
                  phase_nxt = smbht_pkg::PH_CMD;
                  exp_nxt = smbht_pkg::ST_DATA_TX;
                end
              end
              smbht_pkg::PH_CMD: begin
                if (blk_w) begin
                  r[0].phy_op = smbht_pkg::OP_SEND;
                  r[0].tx_byte = scnt_r;
                  n = 2'd1;
                  phase_nxt = smbht_pkg::PH_WCOUNT;
                  exp_nxt = smbht_pkg::ST_DATA_TX;
                end else do_wd = 1'b1;
              end
              smbht_pkg::PH_WDATA: do_wd = 1'b1;
              smbht_pkg::PH_WCOUNT, smbht_pkg::PH_PAYLOAD: do_pl = 1'b1;
              smbht_pkg::PH_RSTART: begin
                r[0].phy_op = smbht_pkg::OP_SEND;
                r[0].tx_byte = {addr_r, 1'b1};
                n = 2'd1;
                phase_nxt = smbht_pkg::PH_ADDRR;
                exp_nxt = smbht_pkg::ST_ADDRR;
              end
              smbht_pkg::PH_ADDRR: begin
                bc = '0;
                acc = '0;
                if (blk_r) begin
                  r[0].phy_op = smbht_pkg::OP_RACK;
                  n = 2'd1;
                  phase_nxt = smbht_pkg::PH_RLEN;
                  exp_nxt = smbht_pkg::ST_RX_ACK;
                end else do_rx = 1'b1;
              end
              smbht_pkg::PH_RLEN: begin
                rl = item.phy_rx_byte;
                if (rl == 8'd0) do_fin = 1'b1;
                else do_rx = 1'b1;
              end
              smbht_pkg::PH_RDATA: begin
                if (blk_r) begin
                  r[0].out_kind = smbht_pkg::OK_RX;
                  r[0].rx_index = bcnt_r;
                  r[0].rx_data  = item.phy_rx_byte;
                  n = 2'd1;
                end else if (bcnt_r < 8'd8) begin
                  acc = acc_r | ({56'd0, item.phy_rx_byte} << {bcnt_r[2:0], 3'b000});
                end
                bc = bcnt_inc;
                if (bcnt_inc < rlen_r) do_rx = 1'b1;
                else do_fin = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      smbht_pkg::FN_PAY: begin
        if (phase_r == smbht_pkg::PH_PAYREQ) begin
          bc = bcnt_inc;
          r[0].phy_op = smbht_pkg::OP_SEND;
          r[0].tx_byte = item.payload_byte;
          n = 2'd1;
          phase_nxt = smbht_pkg::PH_PAYLOAD;
          exp_nxt = smbht_pkg::ST_DATA_TX;
        end
      end
      default: ;
    endcase

    // write-data step: next fixed byte, else move on to the read or stop
    if (do_wd) begin
      if (bcnt_r < scnt_r && bcnt_r < 8'd8) begin
        r[0].phy_op = smbht_pkg::OP_SEND;
        r[0].tx_byte = val_r[{bcnt_r[2:0], 3'b000} +: 8];
        n = 2'd1;
        bc = bcnt_inc;
        phase_nxt = smbht_pkg::PH_WDATA;
        exp_nxt = smbht_pkg::ST_DATA_TX;
      end else do_aw = 1'b1;
    end
    if (do_pl) begin
      if (bcnt_r < scnt_r) begin
        r[0].out_kind = smbht_pkg::OK_PREQ;
        n = 2'd1;
        phase_nxt = smbht_pkg::PH_PAYREQ;
      end else do_aw = 1'b1;
    end
    if (do_aw) begin
      if (smbht_pkg::rd_bytes(kind_r) != 4'd0 || blk_r) begin
        r[0].phy_op = smbht_pkg::OP_RSTART;
        n = 2'd1;
        phase_nxt = smbht_pkg::PH_RSTART;
        exp_nxt = smbht_pkg::ST_RSTART;
      end else do_fin = 1'b1;
    end
    if (do_rx) begin
      r[n].phy_op = (bc + 8'd1 < rl) ? smbht_pkg::OP_RACK : smbht_pkg::OP_RNACK;
      exp_nxt = (bc + 8'd1 < rl) ? smbht_pkg::ST_RX_ACK : smbht_pkg::ST_RX_NACK;
      n = n + 2'd1;
      phase_nxt = smbht_pkg::PH_RDATA;
    end
    if (do_fin) begin
      r[n].phy_op = smbht_pkg::OP_STOP;
      r[n + 2'd1].out_kind = smbht_pkg::OK_DONE;
      if (!blk_r) r[n + 2'd1].read_value = acc;
      else r[n + 2'd1].rx_count = rl;
      n = n + 2'd2;
      phase_nxt = smbht_pkg::PH_IDLE;
      exp_nxt = '0;
    end
    if (n != 2'd0) r[n - 2'd1].last_result = 1'b1;

    bcnt_nxt = bc;
    acc_nxt  = acc;
    rlen_nxt = rl;
    res.cnt = n;
    res.r0 = r[0];
    res.r1 = r[1];
    res.r2 = r[2];
  end

endmodule

>>> rtl/smbht_outq.sv
// ----------------------------------------------------------------------------
// SMBus host sequencer result queue
// Holds one item's result set and hands results out one per transfer.
// ----------------------------------------------------------------------------
module smbht_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  smbht_pkg::res_set_t  res,
  output logic                 empty_next,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smbht_pkg::out_item_t out_data
);

  smbht_pkg::out_item_t slot_r [3];
  logic [1:0] cnt_r, pos_r;
  logic last_take;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[pos_r];
  assign last_take = out_valid && out_ready && (pos_r + 2'd1 == cnt_r);
  // free after this edge: either empty or handing out its last result
  assign empty_next = !out_valid || last_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (load) begin
      cnt_r <= res.cnt;
      pos_r <= '0;
    end else if (last_take) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (out_valid && out_ready) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r[0] <= res.r0;
      slot_r[1] <= res.r1;
      slot_r[2] <= res.r2;
    end
  end

endmodule

>>> rtl/smbus_host_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SMBus host transaction sequencer
// Results of an item appear in the cycle after its transfer. With out_ready
// high, throughput is one item per cycle while each item yields at most one
// result; an item with two or three results holds the input for that many
// output transfers (three-slot result register empties one result a cycle).
// Reset: synchronous active-low; phase idle, all transaction state cleared.
// ----------------------------------------------------------------------------
module smbus_host_transaction_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smbht_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smbht_pkg::out_item_t out_data
);

  smbht_pkg::res_set_t res;
  logic acc_in;
  logic load;
  logic q_free;

  // The core evaluates the incoming item directly; the queue is the result
  // register. A new item is taken once the queue will be free this edge.
  assign in_ready = q_free;
  assign acc_in   = in_valid && in_ready;
  assign load     = acc_in && (res.cnt != 2'd0);

  smbht_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (acc_in),
    .item     (in_data),
    .res      (res)
  );

  smbht_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res        (res),
    .empty_next (q_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // No more than three results from one item; with three, the third is last
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |-> (res.cnt != 2'd3 || res.r2.last_result))
    else $error("result count and last flag disagree");

  // A done result always closes the item's results
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_kind == smbht_pkg::OK_DONE) |-> out_data.last_result)
    else $error("done result not last");

  // Queue loaded only when free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> q_free)
    else $error("result queue overrun");

endmodule
